// ===== hdl/aes_pkg.sv =====
package aes_pkg;

  localparam int unsigned NumRounds = 10;

  localparam logic CmdEncrypt = 1'b0;
  localparam logic CmdDecrypt = 1'b1;

  localparam logic [0:0] RegKeyUpper = 1'b0;
  localparam logic [0:0] RegKeyLower = 1'b1;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 64;

  typedef struct packed {
    logic        command;
    logic [63:0] block_upper;
    logic [63:0] block_lower;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_upper;
    logic [63:0] out_lower;
  } out_item_t;

  // Data handed from one round cell to the next.
  typedef struct packed {
    logic         vld;
    logic         dec;
    logic [127:0] st;
  } cell_bus_t;

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] x, input logic [3:0] y);
    logic [7:0] acc;
    logic [7:0] a;
    acc = 8'h00;
    a = x;
    for (int n = 0; n < 4; n++) begin
      if (y[n]) acc = acc ^ a;
      a = xtime(a);
    end
    gmul = acc;
  endfunction

  function automatic logic [7:0] gf_full(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] acc;
    logic [7:0] a;
    acc = 8'h00;
    a = x;
    for (int n = 0; n < 8; n++) begin
      if (y[n]) acc = acc ^ a;
      a = xtime(a);
    end
    gf_full = acc;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] p;
    // b^254 by square and multiply
    r = 8'h01;
    p = b;
    for (int k = 1; k < 8; k++) begin
      p = gf_full(p, p);
      r = gf_full(r, p);
    end
    ginv = r;
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] v, input int unsigned s);
    rotl = (v << s) | (v >> (8 - s));
  endfunction

  // S-box tables are built at elaboration and end up as constant lookups.
  function automatic logic [2047:0] build_fwd_box();
    logic [2047:0] t;
    logic [7:0] i;
    t = '0;
    for (int v = 0; v < 256; v++) begin
      i = ginv(8'(v));
      t[8 * v +: 8] = i ^ rotl(i, 1) ^ rotl(i, 2) ^ rotl(i, 3) ^ rotl(i, 4) ^ 8'h63;
    end
    build_fwd_box = t;
  endfunction

  function automatic logic [2047:0] build_inv_box();
    logic [2047:0] f;
    logic [2047:0] t;
    logic [7:0] s;
    f = build_fwd_box();
    t = '0;
    for (int v = 0; v < 256; v++) begin
      s = f[8 * v +: 8];
      t[8 * s +: 8] = 8'(v);
    end
    build_inv_box = t;
  endfunction

  localparam logic [2047:0] FwdBox = build_fwd_box();
  localparam logic [2047:0] InvBox = build_inv_box();

  function automatic logic [7:0] sbox(input logic [7:0] v);
    sbox = FwdBox[{v, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] s);
    inv_sbox = InvBox[{s, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] byte_at(input logic [127:0] s, input int unsigned n);
    byte_at = s[127 - 8 * n -: 8];
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv)
          t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = inv_sbox(byte_at(s, r + 4 * c));
        else
          t[127 - 8 * (r + 4 * c) -: 8] = sbox(byte_at(s, r + 4 * ((c + r) % 4)));
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [3:0] m [4];
    logic [7:0] v;
    if (inv) begin
      m[0] = 4'd14; m[1] = 4'd11; m[2] = 4'd13; m[3] = 4'd9;
    end else begin
      m[0] = 4'd2; m[1] = 4'd3; m[2] = 4'd1; m[3] = 4'd1;
    end
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) v = v ^ gmul(byte_at(s, 4 * c + k), m[(k + 4 - r) % 4]);
        t[127 - 8 * (4 * c + r) -: 8] = v;
      end
    end
    mix = t;
  endfunction

  function automatic logic [127:0] next_rkey(input logic [127:0] k, input logic [7:0] rcon);
    logic [31:0] w [4];
    logic [31:0] t;
    for (int i = 0; i < 4; i++) w[i] = k[127 - 32 * i -: 32];
    t = {sbox(w[3][23:16]) ^ rcon, sbox(w[3][15:8]), sbox(w[3][7:0]), sbox(w[3][31:24])};
    w[0] = w[0] ^ t;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    next_rkey = {w[0], w[1], w[2], w[3]};
  endfunction

  function automatic logic [7:0] rcon_of(input int unsigned r);
    logic [7:0] c;
    c = 8'h01;
    for (int i = 1; i < 16; i++) if (i < r) c = xtime(c);
    rcon_of = c;
  endfunction

endpackage

// ===== hdl/aes128_block_cipher.sv =====
// Channel  Ports                         Transfer
// input    start, busy, in_item          start && !busy
// result   out_strobe, out_item          out_strobe (one cycle, no stall)
// config   cfg_we, cfg_index, cfg_data   cfg_we
//
// One block enters per clock while busy is low. A transfer lands in the input
// key-add register, then passes one registered round cell per round before the
// result strobes.
// busy stays high after reset and after each key write,
// while the registered key schedule settles. Reset clears the valid flags and
// the key registers. The result side never stalls.
module aes128_block_cipher #(
  parameter int unsigned ROUNDS = aes_pkg::NumRounds
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  aes_pkg::in_item_t                 in_item,
  output logic                              out_strobe,
  output aes_pkg::out_item_t                out_item,
  input  logic                              cfg_we,
  input  logic [aes_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [aes_pkg::CfgDataW-1:0]      cfg_data
);
  import aes_pkg::*;

  localparam int unsigned SettleW = $clog2(ROUNDS + 2);

  logic [63:0] key_hi_r;
  logic [63:0] key_lo_r;
  logic [SettleW-1:0] settle_r;
  logic [(ROUNDS+1)*128-1:0] rkeys;
  cell_bus_t bus [ROUNDS+1];
  cell_bus_t in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegKeyUpper: key_hi_r <= cfg_data;
        RegKeyLower: key_lo_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold off input until the new round keys reach the last schedule stage.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) settle_r <= SettleW'(ROUNDS + 1);
    else if (settle_r != '0) settle_r <= settle_r - 1'b1;
  end

  aes_key_sched #(.ROUNDS(ROUNDS)) u_ks (
    .clk(clk), .key({key_hi_r, key_lo_r}), .rkeys(rkeys)
  );

  // Initial whitening stage.
  always_ff @(posedge clk) begin
    if (!rst_n) in_r.vld <= 1'b0;
    else in_r.vld <= start && !busy;
    in_r.dec <= in_item.command;
    in_r.st  <= {in_item.block_upper, in_item.block_lower} ^
                ((in_item.command == CmdDecrypt) ? rkeys[ROUNDS*128 +: 128] : rkeys[127:0]);
  end

  assign bus[0] = in_r;

  for (genvar g = 1; g <= ROUNDS; g++) begin : g_cell
    aes_round_cell u_cell (
      .clk(clk), .rst_n(rst_n), .last(g == ROUNDS),
      .enc_key(rkeys[g*128 +: 128]),
      .dec_key(rkeys[(ROUNDS-g)*128 +: 128]),
      .din(bus[g-1]), .dout(bus[g])
    );
  end

  assign busy = (settle_r != '0);
  assign out_strobe = bus[ROUNDS].vld;
  assign out_item = '{out_upper: bus[ROUNDS].st[127:64], out_lower: bus[ROUNDS].st[63:0]};
endmodule

// ===== hdl/aes_key_sched.sv =====
module aes_key_sched #(
  parameter int unsigned ROUNDS = aes_pkg::NumRounds
) (
  input  logic                 clk,
  input  logic [127:0]         key,
  output logic [(ROUNDS+1)*128-1:0] rkeys
);
  import aes_pkg::*;

  // The user must change the key only while idle; the block itself does not enforce
  // this. The schedule is registered one round per stage.
  logic [127:0] rk_r [ROUNDS+1];

  always_ff @(posedge clk) begin
    rk_r[0] <= key;
    for (int r = 1; r <= ROUNDS; r++)
      rk_r[r] <= next_rkey(rk_r[r-1], rcon_of(r));
  end

  always_comb begin
    for (int r = 0; r <= ROUNDS; r++) rkeys[r*128 +: 128] = rk_r[r];
  end
endmodule

// ===== hdl/aes_round_cell.sv =====
module aes_round_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                last,
  input  logic [127:0]        enc_key,
  input  logic [127:0]        dec_key,
  input  aes_pkg::cell_bus_t  din,
  output aes_pkg::cell_bus_t  dout
);
  import aes_pkg::*;

  logic         vld_r;
  logic         dec_r;
  logic [127:0] st_r;
  logic [127:0] st_nxt;
  logic [127:0] ss;

  always_comb begin
    ss = sub_shift(din.st, din.dec);
    if (din.dec)
      st_nxt = last ? (ss ^ dec_key) : mix(ss ^ dec_key, 1'b1);
    else
      st_nxt = last ? (ss ^ enc_key) : (mix(ss, 1'b0) ^ enc_key);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= din.vld;
    dec_r <= din.dec;
    st_r  <= st_nxt;
  end

  assign dout = '{vld: vld_r, dec: dec_r, st: st_r};
endmodule

// ===== sim/tb_aes128_block_cipher.sv =====
`timescale 1ns / 1ps

module tb_aes128_block_cipher;
  import aes_pkg::*;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned Settle = 2 * NumRounds + 8;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_strobe;
  out_item_t out_item;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  aes128_block_cipher DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [7:0] fwd_sub [256];
  logic [7:0] rev_sub [256];
  logic [127:0] cipher_key;

  in_item_t blocks_pending[$];
  out_item_t blocks_due[$];

  int unsigned mismatches;
  int unsigned n_sent, n_checked, n_enc, n_dec, n_keys;
  int unsigned idle_cycles;
  int unsigned gap_left;
  logic calm;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [7:0] gf_mult(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] acc;
    acc = 8'h00;
    for (int n = 0; n < 8; n++) begin
      if (y[n]) acc ^= x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [7:0] rot8(input logic [7:0] v, input int s);
    return (v << s) | (v >> (8 - s));
  endfunction

  // Full AES-128 of one block; round keys rebuilt from the current key.
  function automatic logic [127:0] aes_result(input logic cmd, input logic [127:0] blk,
                                              input logic [127:0] key);
    logic [7:0] rk [11][16];
    logic [7:0] w [44][4];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a [4];
    logic [7:0] tw [4];
    logic [7:0] rc;
    logic [7:0] f;
    logic [7:0] m [4];
    logic [7:0] v;
    logic [127:0] res;
    int r;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) w[i / 4][i % 4] = key[127 - 8 * i -: 8];
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) tw[j] = w[i - 1][j];
      if (i % 4 == 0) begin
        f = tw[0];
        tw[0] = fwd_sub[tw[1]] ^ rc;
        tw[1] = fwd_sub[tw[2]];
        tw[2] = fwd_sub[tw[3]];
        tw[3] = fwd_sub[f];
        rc = gf_mult(rc, 8'h02);
      end
      for (int j = 0; j < 4; j++) w[i][j] = w[i - 4][j] ^ tw[j];
    end
    for (int i = 0; i < 11; i++)
      for (int j = 0; j < 16; j++) rk[i][j] = w[4 * i + j / 4][j % 4];
    for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
    if (cmd == CmdDecrypt) begin
      m[0] = 8'd14; m[1] = 8'd11; m[2] = 8'd13; m[3] = 8'd9;
    end else begin
      m[0] = 8'd2; m[1] = 8'd3; m[2] = 8'd1; m[3] = 8'd1;
    end
    for (int step = 0; step <= 10; step++) begin
      r = (cmd == CmdDecrypt) ? 10 - step : step;
      if (step > 0) begin
        // byte substitution and row rotation
        for (int rr = 0; rr < 4; rr++)
          for (int c = 0; c < 4; c++) begin
            if (cmd == CmdDecrypt) t[rr + 4 * ((c + rr) % 4)] = rev_sub[s[rr + 4 * c]];
            else t[rr + 4 * c] = fwd_sub[s[rr + 4 * ((c + rr) % 4)]];
          end
        s = t;
      end
      if (cmd != CmdDecrypt && step > 0 && step < 10) begin
        for (int c = 0; c < 4; c++) begin
          for (int k = 0; k < 4; k++) a[k] = s[4 * c + k];
          for (int rr = 0; rr < 4; rr++) begin
            v = 8'h00;
            for (int k = 0; k < 4; k++) v ^= gf_mult(m[(k + 4 - rr) % 4], a[k]);
            s[4 * c + rr] = v;
          end
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= rk[r][i];
      // inverse mix follows the key add on the decrypt side
      if (cmd == CmdDecrypt && step > 0 && step < 10) begin
        for (int c = 0; c < 4; c++) begin
          for (int k = 0; k < 4; k++) a[k] = s[4 * c + k];
          for (int rr = 0; rr < 4; rr++) begin
            v = 8'h00;
            for (int k = 0; k < 4; k++) v ^= gf_mult(m[(k + 4 - rr) % 4], a[k]);
            s[4 * c + rr] = v;
          end
        end
      end
    end
    for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
    return res;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (blocks_pending.size() > 0) begin
      start <= 1'b1;
      in_item <= blocks_pending.pop_front();
      if ($urandom_range(0, 63) == 0) calm <= ~calm;
      gap_left <= calm ? 0 : $urandom_range(0, 7);
    end else begin
      start <= 1'b0;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    logic [127:0] want;
    out_item_t exp_item;
    if (rst_n) begin
      if ((start && !busy) || out_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transfer for %0d cycles", IdleLimit);
        $display("tb_aes128_block_cipher: errors");
        $finish;
      end
      if (start && !busy) begin
        want = aes_result(in_item.command, {in_item.block_upper, in_item.block_lower},
                          cipher_key);
        blocks_due.push_back(out_item_t'(want));
        n_sent++;
        if (in_item.command == CmdDecrypt) n_dec++;
        else n_enc++;
      end
      if (out_strobe) begin
        if (blocks_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_item);
        end else begin
          exp_item = blocks_due.pop_front();
          n_checked++;
          if (out_item.out_upper !== exp_item.out_upper ||
              out_item.out_lower !== exp_item.out_lower) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h_%h got %h_%h", exp_item.out_upper,
                       exp_item.out_lower, out_item.out_upper, out_item.out_lower);
          end
        end
      end
    end
  end

  task automatic drain();
    while (blocks_pending.size() > 0 || start || blocks_due.size() > 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic load_key(input logic [63:0] up, input logic [63:0] lo);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= RegKeyUpper; cfg_data <= up;
    @(negedge clk);
    cfg_index <= RegKeyLower; cfg_data <= lo;
    @(negedge clk);
    cfg_we <= 1'b0;
    cipher_key = {up, lo};
    n_keys++;
    repeat (Settle) @(posedge clk);
  endtask

  task automatic queue_block(input logic cmd, input logic [63:0] up, input logic [63:0] lo);
    in_item_t it;
    it.command = cmd; it.block_upper = up; it.block_lower = lo;
    blocks_pending.push_back(it);
  endtask

  task automatic queue_edges();
    for (int c = 0; c < 2; c++) begin
      queue_block(logic'(c), 64'h0, 64'h0);
      queue_block(logic'(c), '1, '1);
      queue_block(logic'(c), 64'h8000000000000000, 64'h1);
      queue_block(logic'(c), 64'h00112233_44556677, 64'h8899aabb_ccddeeff);
    end
  endtask

  initial begin
    logic [7:0] inv;
    logic [63:0] ku, kl;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++) if (gf_mult(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      fwd_sub[x] = inv ^ rot8(inv, 1) ^ rot8(inv, 2) ^ rot8(inv, 3) ^ rot8(inv, 4) ^ 8'h63;
      rev_sub[fwd_sub[x]] = x[7:0];
    end
    cipher_key = '0;
    mismatches = 0; n_sent = 0; n_checked = 0; n_enc = 0; n_dec = 0; n_keys = 0;
    idle_cycles = 0; gap_left = 0; calm = 1'b0;
    rst_n = 1'b0; start = 1'b0; in_item = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset key, standard key, all-ones key
    queue_edges();
    drain();
    load_key(64'h00010203_04050607, 64'h08090a0b_0c0d0e0f);
    queue_edges();
    queue_block(CmdDecrypt, 64'h69c4e0d8_6a7b0430, 64'hd8cdb780_70b4c55a);
    drain();
    load_key('1, '1);
    queue_edges();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      ku = {$urandom, $urandom};
      kl = {$urandom, $urandom};
      load_key(ku, kl);
      for (int i = 0; i < 260; i++) begin
        case ($urandom_range(0, 15))
          0: queue_block(logic'($urandom), '0, {$urandom, $urandom});
          1: queue_block(logic'($urandom), '1, {$urandom, $urandom});
          2: queue_block(logic'($urandom), {$urandom, $urandom}, '1);
          default: queue_block(logic'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
        endcase
      end
      drain();
    end
    load_key('0, '0);
    queue_edges();
    drain();

    $display("covered %0d blocks (%0d encrypt, %0d decrypt) under %0d key loads",
             n_sent, n_enc, n_dec, n_keys);
    $display("%0d results checked, %0d mismatches", n_checked, mismatches);
    if (mismatches == 0 && blocks_due.size() == 0) begin
      $display("tb_aes128_block_cipher: clean");
    end else begin
      $display("tb_aes128_block_cipher: errors");
    end
    $finish;
  end

endmodule
